// ===== hw/rtl/rsum_pkg.sv =====
`default_nettype none
package rsum_pkg;

	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int SIZE_W     = 7;
	localparam int ELEM_W     = 16;
	localparam int RSUM_W     = 22;
	localparam int SUM_W      = 28;
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int MEM_DEPTH  = 1 << ADDR_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SIZE_W;

	localparam logic [SIZE_W-1:0] MAX_ROWS = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] MAX_COLS = SIZE_W'(64);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

	// controller to datapath commands
	typedef struct packed {
		logic load_start;
		logic load_end;
		logic query_start;
		logic query_mid;
		logic query_end;
	} dp_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rsum_if.sv =====
`default_nettype none
interface rsum_in_if;
	logic                               valid;
	logic                               ready;
	logic                               command;
	logic signed [rsum_pkg::ELEM_W-1:0] element_value;
	logic        [rsum_pkg::ROW_W-1:0]  top_row;
	logic        [rsum_pkg::COL_W-1:0]  left_col;
	logic        [rsum_pkg::ROW_W-1:0]  bottom_row;
	logic        [rsum_pkg::COL_W-1:0]  right_col;

	modport source (
		output valid, command, element_value, top_row, left_col, bottom_row, right_col,
		input  ready
	);
	modport sink (
		input  valid, command, element_value, top_row, left_col, bottom_row, right_col,
		output ready
	);
endinterface

interface rsum_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [rsum_pkg::SUM_W-1:0] region_sum;
	logic                              query_error;

	modport source (output valid, region_sum, query_error, input ready);
	modport sink (input valid, region_sum, query_error, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/region_sum_table_2d_top.sv =====
`default_nettype none
// a load item is written into the table in the cycle after it is accepted; a query reads in
// its start and ST_Q_MID steps, and its result is registered when ST_Q_END finds the output slot free
// no item is accepted in ST_LOAD_WR or ST_Q_MID, due to the two read ports of the table memory
// (four reads per query) and the read-then-write of each load; ST_Q_END can take the next item
// reset: asynchronous, clears load position, running sum, table-complete flag and
// output valid, sizes return to 64 x 64; table contents are not cleared
module region_sum_table_2d_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rsum_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rsum_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	rsum_in_if.sink                                  items,
	rsum_out_if.source                               results
);
	import rsum_pkg::*;

	dp_cmd_t cmd;

	// controller: sequences load (read above, write) and query (two read pairs)
	rsum_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (items.valid),
		.in_command (items.command),
		.in_ready   (items.ready),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.cmd        (cmd)
	);

	// datapath: size registers, load position, running row sum, table memory
	rsum_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.element_value (items.element_value),
		.top_row       (items.top_row),
		.left_col      (items.left_col),
		.bottom_row    (items.bottom_row),
		.right_col     (items.right_col),
		.region_sum    (results.region_sum),
		.query_error   (results.query_error)
	);

	// an error result always carries a zero sum
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.query_error |-> results.region_sum == '0)
		else $error("error result with nonzero sum");

	// a query always takes its second read pair in the next cycle
	a_query_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.query_start |=> cmd.query_mid)
		else $error("query second read missing");

	// a load writes in the next cycle and blocks new items meanwhile
	a_load_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_start |=> cmd.load_end && !items.ready)
		else $error("load write missing");

	// start, middle and write steps never overlap
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_start, cmd.query_start, cmd.query_mid, cmd.load_end}))
		else $error("overlapping datapath commands");
endmodule
`default_nettype wire

// ===== hw/rtl/rsum_ctrl.sv =====
`default_nettype none
module rsum_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_command,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rsum_pkg::dp_cmd_t      cmd
);
	import rsum_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_LOAD_WR = 4'b0010,
		ST_Q_MID   = 4'b0100,
		ST_Q_END   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_Q_END) && slot_free);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.load_start  = accept && (in_command == CMD_LOAD);
		cmd.query_start = accept && (in_command == CMD_QUERY);
		cmd.load_end    = (state_q == ST_LOAD_WR);
		cmd.query_mid   = (state_q == ST_Q_MID);
		cmd.query_end   = (state_q == ST_Q_END) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_command == CMD_QUERY) ? ST_Q_MID : ST_LOAD_WR;
				end
			end
			ST_LOAD_WR: begin
				state_d = ST_IDLE;
			end
			ST_Q_MID: begin
				state_d = ST_Q_END;
			end
			ST_Q_END: begin
				if (slot_free) begin
					if (accept) begin
						state_d = (in_command == CMD_QUERY) ? ST_Q_MID : ST_LOAD_WR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.query_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rsum_dp.sv =====
`default_nettype none
module rsum_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic        [rsum_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [rsum_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire rsum_pkg::dp_cmd_t                   cmd,
	input  wire logic signed [rsum_pkg::ELEM_W-1:0]  element_value,
	input  wire logic        [rsum_pkg::ROW_W-1:0]   top_row,
	input  wire logic        [rsum_pkg::COL_W-1:0]   left_col,
	input  wire logic        [rsum_pkg::ROW_W-1:0]   bottom_row,
	input  wire logic        [rsum_pkg::COL_W-1:0]   right_col,
	output logic signed      [rsum_pkg::SUM_W-1:0]   region_sum,
	output logic                                     query_error
);
	import rsum_pkg::*;

	// configuration and load position
	logic        [SIZE_W-1:0] num_rows_q, num_cols_q;
	logic        [SIZE_W-1:0] rows_used, cols_used;
	logic signed [RSUM_W-1:0] rs_q;
	logic        [ROW_W-1:0]  load_row_q;
	logic        [COL_W-1:0]  load_col_q;
	logic                     complete_q;

	// load path
	logic                     restart;
	logic        [ROW_W-1:0]  eff_r;
	logic        [COL_W-1:0]  eff_c;
	logic signed [RSUM_W-1:0] eff_rs, new_rs;
	logic        [SIZE_W-1:0] next_r;
	logic                     last_col;
	logic        [ADDR_W-1:0] wr_addr_s1;
	logic signed [RSUM_W-1:0] wr_rs_s1;
	logic                     above_zero_s1;
	logic signed [SUM_W-1:0]  wr_data;

	// query path
	logic        [ROW_W-1:0]  qt_q, qb_q;
	logic        [COL_W-1:0]  ql_q;
	logic                     q_err;
	logic                     err_s1, top_zero_s1;
	logic                     err_s2, left_zero_s2, corner_zero_s2;
	logic signed [SUM_W-1:0]  acc_s2;
	logic signed [SUM_W-1:0]  sum;

	// memory
	logic signed [SUM_W-1:0]  mem [MEM_DEPTH];
	logic signed [SUM_W-1:0]  rd_a_q, rd_b_q;
	logic        [ADDR_W-1:0] addr_a, addr_b;
	logic                     rd_en;

	always_comb begin
		rows_used = num_rows_q;
		if (num_rows_q == '0) begin
			rows_used = SIZE_W'(1);
		end else if (num_rows_q > MAX_ROWS) begin
			rows_used = MAX_ROWS;
		end
		cols_used = num_cols_q;
		if (num_cols_q == '0) begin
			cols_used = SIZE_W'(1);
		end else if (num_cols_q > MAX_COLS) begin
			cols_used = MAX_COLS;
		end
	end

	// a finished table or a position past the size restarts at the origin
	assign restart  = complete_q || ({1'b0, load_row_q} >= rows_used) ||
		({1'b0, load_col_q} >= cols_used);
	assign eff_r    = restart ? '0 : load_row_q;
	assign eff_c    = restart ? '0 : load_col_q;
	assign eff_rs   = restart ? '0 : rs_q;
	assign new_rs   = eff_rs + {{(RSUM_W-ELEM_W){element_value[ELEM_W-1]}}, element_value};
	assign last_col = ({1'b0, eff_c} + SIZE_W'(1)) >= cols_used;
	assign next_r   = {1'b0, eff_r} + SIZE_W'(1);

	assign q_err = !complete_q || (top_row > bottom_row) || (left_col > right_col) ||
		({1'b0, bottom_row} >= rows_used) || ({1'b0, right_col} >= cols_used);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= MAX_ROWS;
			num_cols_q <= MAX_COLS;
			rs_q       <= '0;
			load_row_q <= '0;
			load_col_q <= '0;
			complete_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS) begin
				if (cfg_index == REG_NUM_ROWS) begin
					num_rows_q <= cfg_wdata;
				end else begin
					num_cols_q <= cfg_wdata;
				end
				rs_q       <= '0;
				load_row_q <= '0;
				load_col_q <= '0;
				complete_q <= 1'b0;
			end
		end else if (cmd.load_start) begin
			if (last_col) begin
				rs_q       <= '0;
				load_col_q <= '0;
				if (next_r >= rows_used) begin
					load_row_q <= '0;
					complete_q <= 1'b1;
				end else begin
					load_row_q <= next_r[ROW_W-1:0];
					complete_q <= 1'b0;
				end
			end else begin
				rs_q       <= new_rs;
				load_col_q <= eff_c + COL_W'(1);
				load_row_q <= eff_r;
				complete_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			wr_addr_s1    <= {eff_r, eff_c};
			wr_rs_s1      <= new_rs;
			above_zero_s1 <= (eff_r == '0);
		end
		if (cmd.query_start) begin
			qt_q        <= top_row;
			qb_q        <= bottom_row;
			ql_q        <= left_col;
			err_s1      <= q_err;
			top_zero_s1 <= (top_row == '0);
		end
		if (cmd.query_mid) begin
			acc_s2         <= rd_a_q - (top_zero_s1 ? SUM_W'(0) : rd_b_q);
			err_s2         <= err_s1;
			left_zero_s2   <= (ql_q == '0);
			corner_zero_s2 <= (ql_q == '0) || top_zero_s1;
		end
		if (cmd.query_end) begin
			region_sum  <= err_s2 ? SUM_W'(0) : sum;
			query_error <= err_s2;
		end
	end

	assign sum = acc_s2 - (left_zero_s2 ? SUM_W'(0) : rd_a_q) +
		(corner_zero_s2 ? SUM_W'(0) : rd_b_q);

	// first query pass reads the right-hand column, second the column left of the box
	always_comb begin
		if (cmd.query_mid) begin
			addr_a = {qb_q, ql_q - COL_W'(1)};
			addr_b = {qt_q - ROW_W'(1), ql_q - COL_W'(1)};
		end else if (cmd.query_start) begin
			addr_a = {bottom_row, right_col};
			addr_b = {top_row - ROW_W'(1), right_col};
		end else begin
			addr_a = {eff_r - ROW_W'(1), eff_c};
			addr_b = {eff_r - ROW_W'(1), eff_c};
		end
	end

	assign rd_en   = cmd.load_start || cmd.query_start || cmd.query_mid;
	assign wr_data = (above_zero_s1 ? SUM_W'(0) : rd_a_q) +
		{{(SUM_W-RSUM_W){wr_rs_s1[RSUM_W-1]}}, wr_rs_s1};

	always_ff @(posedge clk) begin
		if (cmd.load_end) begin
			mem[wr_addr_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end
endmodule
`default_nettype wire
